>>> hw/rtl/jel_pkg.sv
// ----------------------------------------------------------------------------
// jel_pkg: shared types and constants for the JSON element locator
// Character codes, scan phases, result codes and the item and result records
// passed between the locator stages.
// ----------------------------------------------------------------------------
package jel_pkg;

  localparam int MAX_REGION = 65536;
  localparam int DEPTH_BITS = 8;
  localparam int POS_W      = 17;
  localparam int OFF_W      = 17;
  localparam int CNT_W      = 17;
  localparam int TGT_W      = 24;
  localparam int SKIP_W     = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [SKIP_W-1:0] SKIP_ONE     = SKIP_W'(1);
  localparam logic [SKIP_W-1:0] SKIP_UNICODE = SKIP_W'(4);

  localparam logic signed [OFF_W-1:0] OFF_NONE = '1;
  localparam logic [CNT_W-1:0]        CNT_MAX  = '1;
  localparam logic [DEPTH_BITS-1:0]   DEPTH_MAX = '1;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_BETWEEN,
    PH_ITEM
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND_COMMA   = 3'd0,
    ST_FOUND_CLOSER  = 3'd1,
    ST_CLOSED_BEFORE = 3'd2,
    ST_WRONG_CLOSER  = 3'd3,
    ST_EMPTY_CLOSER  = 3'd4,
    ST_INPUT_ENDED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       region_end;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic [CNT_W-1:0]         element_count;
    logic signed [OFF_W-1:0]  start_offset;
    logic signed [OFF_W-1:0]  stop_offset;
    logic signed [OFF_W-1:0]  comma_offset;
    logic signed [OFF_W-1:0]  close_offset;
    logic signed [OFF_W-1:0]  open_offset;
    logic signed [OFF_W-1:0]  prior_comma_offset;
  } result_t;

endpackage

>>> hw/rtl/jel_in_stage.sv
// ----------------------------------------------------------------------------
// jel_in_stage: input register
// Captures one byte transfer and holds it until the scan core consumes it.
// ----------------------------------------------------------------------------
module jel_in_stage
  import jel_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  consume,
  output logic  held_valid,
  output item_t held_item
);

  logic  full;
  item_t item;

  assign in_ready   = !full || consume;
  assign held_valid = full;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> hw/rtl/jel_scan_core.sv
// ----------------------------------------------------------------------------
// jel_scan_core: byte scanner state and update logic
// Holds the scan state and the target index, and computes in one step the
// state update and the optional result for the byte in the input register.
// ----------------------------------------------------------------------------
module jel_scan_core
  import jel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [TGT_W-1:0] cfg_wdata,
  input  item_t            item,
  input  logic             step,
  output logic             produce,
  output result_t          result
);

  logic [TGT_W-1:0] target_index;

  phase_t                  scan_phase,        scan_phase_next;
  logic                    closer_is_bracket, closer_is_bracket_next;
  logic [DEPTH_BITS-1:0]   brace_depth,       brace_depth_next;
  logic [DEPTH_BITS-1:0]   bracket_depth,     bracket_depth_next;
  logic                    inside_string,     inside_string_next;
  logic                    escape_pending,    escape_pending_next;
  logic [SKIP_W-1:0]       skip_count,        skip_count_next;
  logic [POS_W-1:0]        position,          position_next;
  logic [CNT_W-1:0]        count_reg,         count_reg_next;
  logic                    draining,          draining_next;
  logic signed [OFF_W-1:0] start_off,  start_off_next;
  logic signed [OFF_W-1:0] stop_off,   stop_off_next;
  logic signed [OFF_W-1:0] comma_off,  comma_off_next;
  logic signed [OFF_W-1:0] close_off,  close_off_next;
  logic signed [OFF_W-1:0] open_off,   open_off_next;
  logic signed [OFF_W-1:0] prior_off,  prior_off_next;
  logic signed [OFF_W-1:0] last_comma, last_comma_next;

  logic [7:0]              b;
  logic                    last;
  logic [7:0]              closer;
  logic signed [OFF_W-1:0] pos;
  logic                    done;
  status_t                 status;
  logic [TGT_W-1:0]        item_index;

  function automatic logic [DEPTH_BITS-1:0] sat_inc(input logic [DEPTH_BITS-1:0] d);
    return (d == DEPTH_MAX) ? d : d + DEPTH_BITS'(1);
  endfunction

  assign b          = item.char_byte;
  assign last       = item.region_end;
  assign closer     = closer_is_bracket ? CH_RBRACK : CH_RBRACE;
  assign pos        = OFF_W'(position);
  // Index of the current element; the count is at least one inside an element.
  assign item_index = TGT_W'(count_reg - CNT_W'(1));

  always_comb begin
    scan_phase_next        = scan_phase;
    closer_is_bracket_next = closer_is_bracket;
    brace_depth_next       = brace_depth;
    bracket_depth_next     = bracket_depth;
    inside_string_next     = inside_string;
    escape_pending_next    = escape_pending;
    skip_count_next        = skip_count;
    position_next          = position;
    count_reg_next         = count_reg;
    draining_next          = draining;
    start_off_next         = start_off;
    stop_off_next          = stop_off;
    comma_off_next         = comma_off;
    close_off_next         = close_off;
    open_off_next          = open_off;
    prior_off_next         = prior_off;
    last_comma_next        = last_comma;
    done                   = 1'b0;
    status                 = ST_INPUT_ENDED;

    if (!draining) begin
      if (b == CH_NUL || position >= POS_W'(MAX_REGION)) begin
        done = 1'b1;
      end else begin
        position_next = position + POS_W'(1);
        case (scan_phase)
          PH_SEEK: begin
            if (b == CH_LBRACK || b == CH_LBRACE) begin
              closer_is_bracket_next = (b == CH_LBRACK);
              open_off_next          = pos;
              scan_phase_next        = PH_BETWEEN;
            end
          end
          PH_BETWEEN: begin
            if (b > CH_SPACE) begin
              start_off_next = OFF_NONE;
              stop_off_next  = OFF_NONE;
              comma_off_next = OFF_NONE;
              close_off_next = OFF_NONE;
              if (b == closer) begin
                status = ST_EMPTY_CLOSER;
                done   = 1'b1;
              end else begin
                brace_depth_next   = (b == CH_LBRACE) ? DEPTH_BITS'(1) : '0;
                bracket_depth_next = (b == CH_LBRACK) ? DEPTH_BITS'(1) : '0;
                if (b == CH_QUOTE) begin
                  inside_string_next = 1'b1;
                end
                prior_off_next  = last_comma;
                start_off_next  = pos;
                scan_phase_next = PH_ITEM;
                if (count_reg != CNT_MAX) begin
                  count_reg_next = count_reg + CNT_W'(1);
                end
              end
            end
          end
          PH_ITEM: begin
            if (!inside_string) begin
              if (b == CH_LBRACE) begin
                brace_depth_next = sat_inc(brace_depth);
              end
              if (b == CH_LBRACK) begin
                bracket_depth_next = sat_inc(bracket_depth);
              end
              if (b == CH_QUOTE) begin
                inside_string_next = 1'b1;
              end
            end else if (!escape_pending) begin
              if (b == CH_QUOTE) begin
                inside_string_next = 1'b0;
                skip_count_next    = SKIP_ONE;
              end else if (b == CH_BSLASH) begin
                escape_pending_next = 1'b1;
                skip_count_next     = SKIP_ONE;
              end
            end else begin
              if (b == CH_SLASH || b == CH_LOW_B || b == CH_LOW_F || b == CH_LOW_N ||
                  b == CH_LOW_R || b == CH_LOW_T || b == CH_BSLASH || b == CH_QUOTE) begin
                skip_count_next = SKIP_ONE;
              end else if (b == CH_LOW_U) begin
                skip_count_next = SKIP_UNICODE;
              end
              escape_pending_next = 1'b0;
            end

            // A pending skip swallows this byte; closers and commas count only
            // outside strings.
            if (skip_count_next != '0) begin
              skip_count_next = skip_count_next - SKIP_W'(1);
            end else if (!inside_string_next) begin
              if (b == CH_RBRACE && brace_depth_next != '0) begin
                brace_depth_next = brace_depth_next - DEPTH_BITS'(1);
              end else if (b == CH_RBRACK && bracket_depth_next != '0) begin
                bracket_depth_next = bracket_depth_next - DEPTH_BITS'(1);
              end else if (b == CH_RBRACE || b == CH_RBRACK) begin
                done = 1'b1;
                if (b == closer) begin
                  if (stop_off == OFF_NONE) begin
                    stop_off_next = pos - OFF_W'(1);
                  end
                  close_off_next = pos;
                  status = (item_index == target_index) ? ST_FOUND_CLOSER
                                                        : ST_CLOSED_BEFORE;
                end else begin
                  status = ST_WRONG_CLOSER;
                end
              end else if (b == CH_COMMA) begin
                if (brace_depth_next == '0 && bracket_depth_next == '0) begin
                  stop_off_next   = pos - OFF_W'(1);
                  comma_off_next  = pos;
                  last_comma_next = pos;
                  if (item_index >= target_index) begin
                    status = ST_FOUND_COMMA;
                    done   = 1'b1;
                  end else begin
                    start_off_next  = OFF_NONE;
                    stop_off_next   = OFF_NONE;
                    comma_off_next  = OFF_NONE;
                    close_off_next  = OFF_NONE;
                    scan_phase_next = PH_BETWEEN;
                  end
                end
              end else if (b > CH_SPACE && start_off == OFF_NONE) begin
                start_off_next = pos;
              end
            end
          end
          default: begin
            scan_phase_next = PH_SEEK;
          end
        endcase
      end
      if (!done && last) begin
        status = ST_INPUT_ENDED;
        done   = 1'b1;
      end
    end

    // The result shows the offsets as updated by this byte.
    result.status             = status;
    result.element_count      = count_reg_next;
    result.start_offset       = start_off_next;
    result.stop_offset        = stop_off_next;
    result.comma_offset       = comma_off_next;
    result.close_offset       = close_off_next;
    result.open_offset        = open_off_next;
    result.prior_comma_offset = prior_off_next;
    produce                   = done && !draining;

    if (done && !last) begin
      draining_next = 1'b1;
    end
    if ((done || draining) && last) begin
      scan_phase_next        = PH_SEEK;
      closer_is_bracket_next = 1'b0;
      brace_depth_next       = '0;
      bracket_depth_next     = '0;
      inside_string_next     = 1'b0;
      escape_pending_next    = 1'b0;
      skip_count_next        = '0;
      position_next          = '0;
      count_reg_next         = '0;
      draining_next          = 1'b0;
      start_off_next         = OFF_NONE;
      stop_off_next          = OFF_NONE;
      comma_off_next         = OFF_NONE;
      close_off_next         = OFF_NONE;
      open_off_next          = OFF_NONE;
      prior_off_next         = OFF_NONE;
      last_comma_next        = OFF_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_index <= '0;
    end else if (cfg_we) begin
      target_index <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase        <= PH_SEEK;
      closer_is_bracket <= 1'b0;
      brace_depth       <= '0;
      bracket_depth     <= '0;
      inside_string     <= 1'b0;
      escape_pending    <= 1'b0;
      skip_count        <= '0;
      position          <= '0;
      count_reg         <= '0;
      draining          <= 1'b0;
      start_off         <= OFF_NONE;
      stop_off          <= OFF_NONE;
      comma_off         <= OFF_NONE;
      close_off         <= OFF_NONE;
      open_off          <= OFF_NONE;
      prior_off         <= OFF_NONE;
      last_comma        <= OFF_NONE;
    end else if (step) begin
      scan_phase        <= scan_phase_next;
      closer_is_bracket <= closer_is_bracket_next;
      brace_depth       <= brace_depth_next;
      bracket_depth     <= bracket_depth_next;
      inside_string     <= inside_string_next;
      escape_pending    <= escape_pending_next;
      skip_count        <= skip_count_next;
      position          <= position_next;
      count_reg         <= count_reg_next;
      draining          <= draining_next;
      start_off         <= start_off_next;
      stop_off          <= stop_off_next;
      comma_off         <= comma_off_next;
      close_off         <= close_off_next;
      open_off          <= open_off_next;
      prior_off         <= prior_off_next;
      last_comma        <= last_comma_next;
    end
  end

endmodule

>>> hw/rtl/jel_out_stage.sv
// ----------------------------------------------------------------------------
// jel_out_stage: result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module jel_out_stage
  import jel_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    full;
  result_t held;

  assign can_load   = !full || out_ready;
  assign out_valid  = full;
  assign out_result = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_result;
    end
  end

endmodule

>>> hw/rtl/json_element_locator_unit.sv
// ----------------------------------------------------------------------------
// json_element_locator_unit: locates one top-level element of a JSON region
// Scans the bytes of a region and reports where the element at the target
// index starts and stops, with the surrounding comma and bracket offsets.
//
//   Channel  Direction  Width  Contents
//   s_*      in         8+1    tdata: char_byte; tlast: region_end
//   m_*      out        120+3  tdata: count and six offsets; tuser: status
//   cfg_*    in         24     target_index write
//
// A byte is held in the input register while the scan core works on it;
// a new byte can be accepted every cycle, so the sustained rate is one
// byte per cycle unless a result is held back. A byte goes through the input
// register, and its result through the result register, to the m_* channel.
// A byte that ends the scan waits in the input register while a previous
// result has not been taken; bytes that give no result keep flowing.
// Reset is synchronous and leaves the block ready for a new region with a
// target index of zero.
// ----------------------------------------------------------------------------
module json_element_locator_unit
  import jel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [TGT_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // char_byte
  input  logic             s_tlast,   // region_end
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [119:0]     m_tdata,   // element_count, start_offset, stop_offset,
                                      // comma_offset, close_offset, open_offset,
                                      // prior_comma_offset, one zero pad bit
  output logic [2:0]       m_tuser    // status
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    step;
  logic    produce;
  logic    can_load;
  result_t core_result;
  result_t out_result;

  assign in_item.char_byte  = s_tdata;
  assign in_item.region_end = s_tlast;

  // The held byte advances unless it would end the scan while the result
  // register is still occupied.
  assign step = held_valid && (!produce || can_load);

  jel_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .consume    (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  jel_scan_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (held_item),
    .step      (step),
    .produce   (produce),
    .result    (core_result)
  );

  jel_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (step && produce),
    .load_result (core_result),
    .can_load    (can_load),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  assign m_tuser = out_result.status;
  assign m_tdata = {1'b0,
                    out_result.prior_comma_offset,
                    out_result.open_offset,
                    out_result.close_offset,
                    out_result.comma_offset,
                    out_result.stop_offset,
                    out_result.start_offset,
                    out_result.element_count};

endmodule
